FILE: src/nsc_pkg.sv
package nsc_pkg;

	localparam int unsigned NSC_MAX_LINE = 84;
	localparam int unsigned NSC_LEN_W    = 7;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TILDE  = 8'h7E;

	// verdict for one finished line
	typedef struct packed {
		logic [NSC_LEN_W-1:0] line_length;
		logic                 line_valid;
	} nsc_result_t;

endpackage

FILE: src/nsc_line_fsm.sv
module nsc_line_fsm import nsc_pkg::*; #(
	parameter int unsigned MAX_LINE = NSC_MAX_LINE
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        strict_mode,
	input  logic        step_en,
	input  logic [7:0]  rx_byte,
	output logic        emit,
	output nsc_result_t result
);

	typedef enum logic [2:0] {
		PH_START,
		PH_BODY,
		PH_HEX1,
		PH_HEX2,
		PH_TAIL,
		PH_ENDED
	} phase_t;

	localparam logic [NSC_LEN_W-1:0] MAX_L = NSC_LEN_W'(MAX_LINE);

	phase_t               phase_q, phase_n;
	logic [7:0]           xor_q, xor_n;
	logic [3:0]           nib_q, nib_n;
	logic [NSC_LEN_W-1:0] cnt_q, cnt_n;
	logic                 fail_q, fail_n;
	logic [4:0]           hex;
	logic                 line_end;
	logic                 ok;

	// {digit ok, value}
	function automatic logic [4:0] hex_dec(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39)
			r = {1'b1, 4'(b - 8'h30)};
		else if (b >= 8'h41 && b <= 8'h46)
			r = {1'b1, 4'(b - 8'h37)};
		else if (b >= 8'h61 && b <= 8'h66)
			r = {1'b1, 4'(b - 8'h57)};
		return r;
	endfunction

	always_comb begin
		phase_n = phase_q;
		xor_n   = xor_q;
		nib_n   = nib_q;
		fail_n  = fail_q;
		cnt_n   = (cnt_q < MAX_L) ? cnt_q + 1'b1 : cnt_q;
		hex     = hex_dec(rx_byte);

		if (!fail_q) begin
			unique case (phase_q)
				PH_START: begin
					if (rx_byte == CH_DOLLAR) phase_n = PH_BODY;
					else fail_n = 1'b1;
				end
				PH_BODY: begin
					priority if (rx_byte == CH_STAR) begin
						phase_n = PH_HEX1;
					end else if (rx_byte >= CH_SPACE && rx_byte <= CH_TILDE) begin
						xor_n = xor_q ^ rx_byte;
					end else if (strict_mode) begin
						fail_n = 1'b1;
					end else begin
						// no checksum field: byte is treated as tail
						phase_n = PH_TAIL;
						if (rx_byte == CH_NUL) phase_n = PH_ENDED;
						else if (rx_byte != CH_CR && rx_byte != CH_LF) fail_n = 1'b1;
					end
				end
				PH_HEX1: begin
					if (!hex[4]) fail_n = 1'b1;
					else begin
						nib_n   = hex[3:0];
						phase_n = PH_HEX2;
					end
				end
				PH_HEX2: begin
					if (!hex[4] || {nib_q, hex[3:0]} != xor_q) fail_n = 1'b1;
					else phase_n = PH_TAIL;
				end
				PH_TAIL: begin
					if (rx_byte == CH_NUL) phase_n = PH_ENDED;
					else if (rx_byte != CH_CR && rx_byte != CH_LF) fail_n = 1'b1;
				end
				default: begin
					if (rx_byte != CH_NUL) fail_n = 1'b1;
				end
			endcase
		end

		line_end = (rx_byte == CH_LF) || (cnt_n >= MAX_L);

		ok = 1'b0;
		if (!fail_n) begin
			unique case (phase_n)
				PH_BODY:           ok = !strict_mode;
				PH_TAIL, PH_ENDED: ok = 1'b1;
				default:           ok = 1'b0;
			endcase
		end

		emit               = step_en && line_end;
		result.line_valid  = ok;
		result.line_length = cnt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			xor_q   <= '0;
			nib_q   <= '0;
			cnt_q   <= '0;
			fail_q  <= 1'b0;
		end else if (step_en) begin
			if (line_end) begin
				phase_q <= PH_START;
				xor_q   <= '0;
				nib_q   <= '0;
				cnt_q   <= '0;
				fail_q  <= 1'b0;
			end else begin
				phase_q <= phase_n;
				xor_q   <= xor_n;
				nib_q   <= nib_n;
				cnt_q   <= cnt_n;
				fail_q  <= fail_n;
			end
		end
	end

endmodule

FILE: src/nsc_out_reg.sv
module nsc_out_reg import nsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  nsc_result_t result,
	output logic        space,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata
);

	logic        res_vld_s2;
	nsc_result_t res_s2;

	assign space    = !res_vld_s2 || m_tready;
	assign m_tvalid = res_vld_s2;
	assign m_tdata  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_s2 <= 1'b0;
		end else if (load) begin
			res_vld_s2 <= 1'b1;
		end else if (m_tready) begin
			res_vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) res_s2 <= result;
	end

endmodule

FILE: src/nmea_sentence_checker.sv
// Channel  Dir  Word                         Fields (low bit up)
// s_       in   one received byte            tdata[7:0] rx_byte
// m_       out  one verdict per line         tdata[0] line_valid, tdata[7:1] line_length
// cfg_     in   strict_mode register write   cfg_wdata[0] strict_mode
//
// One byte per cycle sustained while m_ is not stalled. A byte sits in the input
// register, then the line state updates and any verdict lands in the output register,
// so a verdict shows on m_ once the line's last byte has passed the input register.
// Reset clears line state and sets strict_mode; all words in flight are lost.
// A stalled output holds any byte in the input register, which then drops s_tready.
module nmea_sentence_checker import nsc_pkg::*; #(
	parameter int unsigned MAX_LINE = NSC_MAX_LINE
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [0] line_valid, [7:1] line_length
	input  logic       cfg_we,
	input  logic       cfg_wdata  // strict_mode
);

	logic        strict_q;
	logic        vld_s1;
	logic [7:0]  byte_s1;
	logic        space;
	logic        step_en;
	logic        emit;
	nsc_result_t result;

	// the input stage moves on only when the output register can take a verdict
	assign step_en  = vld_s1 && space;
	assign s_tready = !vld_s1 || space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q <= 1'b1;
			vld_s1   <= 1'b0;
		end else begin
			if (cfg_we) strict_q <= cfg_wdata;
			if (s_tready) vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) byte_s1 <= s_tdata;
	end

	nsc_line_fsm #(.MAX_LINE(MAX_LINE)) u_fsm (
		.clk         (clk),
		.arst_n      (arst_n),
		.strict_mode (strict_q),
		.step_en     (step_en),
		.rx_byte     (byte_s1),
		.emit        (emit),
		.result      (result)
	);

	nsc_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (emit),
		.result   (result),
		.space    (space),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

FILE: src/nsc_checker.sv
module nsc_checker import nsc_pkg::*; #(
	parameter int unsigned MAX_LINE = NSC_MAX_LINE
) (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	localparam logic [NSC_LEN_W-1:0] MAX_L = NSC_LEN_W'(MAX_LINE);

	// stalled verdict holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("verdict changed under stall");

	// back-pressure on input only when the output is stuck
	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output stall");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:1] != '0 && m_tdata[7:1] <= MAX_L)
		else $error("line length out of range");

	// a good sentence needs at least the start character and one more byte
	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[7:1] >= NSC_LEN_W'(2))
		else $error("valid line too short");

endmodule

bind nmea_sentence_checker nsc_checker #(.MAX_LINE(MAX_LINE)) u_nsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: bench/nmea_sentence_checker_tb.sv
// Bench for the NMEA sentence checker.
// Bytes go in as words on the s_ side; every finished line gives one verdict word
// on the m_ side. A behavioural copy of the line checker runs alongside, fed with
// each accepted byte, and queues the verdict it expects for every finished line.
// Each verdict word that leaves the block is checked against the oldest entry.
module nmea_sentence_checker_tb;
	import nsc_pkg::*;

	typedef logic [7:0] octet_t;

	// line checker phases, as the block walks through one sentence
	typedef enum logic [2:0] {
		LN_START, // waiting for '$'
		LN_BODY,  // XOR over the printable body
		LN_HEX1,  // first checksum digit
		LN_HEX2,  // second checksum digit
		LN_TAIL,  // only CR / LF allowed, or a NUL that ends the text
		LN_ENDED  // after a NUL, only NULs allowed
	} line_phase_t;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_WAIT  = 4;

	logic   clk      = 1'b0;
	logic   arst_n   = 1'b0;
	logic   s_tvalid = 1'b0;
	logic   s_tready;
	octet_t s_tdata  = '0;   // [7:0] rx_byte
	logic   m_tvalid;
	logic   m_tready = 1'b0;
	logic [7:0] m_tdata;     // [0] line_valid, [7:1] line_length
	logic   cfg_we   = 1'b0;
	logic   cfg_wdata = 1'b0; // strict_mode

	// idling in percent of cycles, changed between test phases
	int unsigned gap_pct   = 0;
	int unsigned stall_pct = 0;

	int unsigned cycle_count = 0;
	int unsigned fail_count  = 0;
	int unsigned bytes_sent  = 0;

	// shadow line state and register
	logic        strict_q;
	line_phase_t ln_phase;
	octet_t      ln_xor;
	logic [3:0]  ln_hi;
	logic [6:0]  ln_count;
	logic        ln_failed;

	nsc_result_t verdicts_due[$];

	nmea_sentence_checker u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver back-pressure, redrawn every cycle
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// verdict checker: each word against the oldest expectation
	always @(posedge clk) begin
		nsc_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (verdicts_due.size() == 0) begin
				$display("%0t: unexpected verdict word, expected none, actual valid=%0b len=%0d",
					$time, got.line_valid, got.line_length);
				fail_count++;
			end else begin
				want = verdicts_due.pop_front();
				if (got.line_valid !== want.line_valid) begin
					$display("%0t: line_valid mismatch, expected %0b, actual %0b",
						$time, want.line_valid, got.line_valid);
					fail_count++;
				end
				if (got.line_length !== want.line_length) begin
					$display("%0t: line_length mismatch, expected %0d, actual %0d",
						$time, want.line_length, got.line_length);
					fail_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- shadow model

	function automatic int hex_nibble(input octet_t b);
		if (b >= "0" && b <= "9") return int'(b - "0");
		if (b >= "A" && b <= "F") return int'(b - "A") + 10;
		if (b >= "a" && b <= "f") return int'(b - "a") + 10;
		return -1;
	endfunction

	task automatic clear_line();
		ln_phase  = LN_START;
		ln_xor    = '0;
		ln_hi     = '0;
		ln_count  = '0;
		ln_failed = 1'b0;
	endtask

	// CR and LF pass, NUL closes the text, anything else kills the line
	task automatic tail_byte(input octet_t b);
		if (b == CH_CR || b == CH_LF)
			return;
		if (b == CH_NUL)
			ln_phase = LN_ENDED;
		else
			ln_failed = 1'b1;
	endtask

	task automatic judge_byte(input octet_t b);
		int          nib;
		nsc_result_t r;
		if (ln_count < NSC_MAX_LINE)
			ln_count++;
		if (!ln_failed) begin
			case (ln_phase)
				LN_START: begin
					if (b == CH_DOLLAR)
						ln_phase = LN_BODY;
					else
						ln_failed = 1'b1;
				end
				LN_BODY: begin
					if (b == CH_STAR) begin
						ln_phase = LN_HEX1;
					end else if (b >= CH_SPACE && b <= CH_TILDE) begin
						ln_xor ^= b;
					end else if (strict_q) begin
						ln_failed = 1'b1;
					end else begin
						// lax mode: body simply ends, byte judged as tail
						ln_phase = LN_TAIL;
						tail_byte(b);
					end
				end
				LN_HEX1: begin
					nib = hex_nibble(b);
					if (nib < 0) begin
						ln_failed = 1'b1;
					end else begin
						ln_hi    = nib[3:0];
						ln_phase = LN_HEX2;
					end
				end
				LN_HEX2: begin
					nib = hex_nibble(b);
					if (nib < 0 || {ln_hi, nib[3:0]} != ln_xor)
						ln_failed = 1'b1;
					else
						ln_phase = LN_TAIL;
				end
				LN_TAIL: tail_byte(b);
				default: begin
					if (b != CH_NUL)
						ln_failed = 1'b1;
				end
			endcase
		end
		// line closes on LF or on reaching the length cap
		if (b == CH_LF || ln_count >= NSC_MAX_LINE) begin
			r.line_length = ln_count;
			r.line_valid  = !ln_failed && (ln_phase == LN_TAIL || ln_phase == LN_ENDED ||
				(ln_phase == LN_BODY && !strict_q));
			verdicts_due.push_back(r);
			clear_line();
		end
	endtask

	// ---------------------------------------------------------------- drivers

	task automatic send_byte(input octet_t b);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		judge_byte(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(octet_t'(s[i]));
	endtask

	// pipeline empty: no verdict owed and the input register flushed
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (verdicts_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic set_strict(input logic mode);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(negedge clk);
		cfg_we    <= 1'b0;
		strict_q   = mode;
	endtask

	function automatic octet_t hex_char(input logic [3:0] n, input bit lower);
		if (n < 10)
			return octet_t'("0") + n;
		return octet_t'((lower ? octet_t'("a") : octet_t'("A")) + n - 10);
	endfunction

	// ---------------------------------------------------------------- tests

	task automatic test_sentence_basics();
		set_strict(1'b1);
		send_text("\n");            // lone LF, no '$'
		send_text("$*00\r\n");      // empty body, XOR zero
		send_text("$A*41\r\n");
		send_text("$J*4a\n");       // lower-case hex digit
		send_text("X$A*41\n");      // wrong start character
		send_text("$A\n");          // no checksum, strict
		set_strict(1'b0);
		send_text("$A\n");          // no checksum, lax
		send_text("$A\r\n");
	endtask

	task automatic test_checksum_faults();
		set_strict(1'b1);
		send_text("$A*42\n");       // wrong value
		send_text("$A*4G\n");       // second digit not hex
		send_text("$A*G1\n");       // first digit not hex
		send_text("$A*4\n");        // line ends before second digit
		send_text("$A*\n");         // line ends before first digit
		send_text("$*00X\n");       // junk after the checksum
		send_byte(CH_DOLLAR);       // top byte value in the body
		send_byte(8'hFF);
		send_byte(CH_LF);
	endtask

	task automatic test_nul_handling();
		set_strict(1'b1);
		send_text("$*00");
		send_byte(CH_NUL);
		send_byte(CH_NUL);
		send_byte(CH_LF);           // LF after NUL padding fails the line
		send_text("$*00");
		send_byte(CH_NUL);
		send_text("X\n");           // text after NUL fails
		set_strict(1'b0);
		send_text("$B");
		send_byte(CH_NUL);          // lax: NUL ends the body
		send_byte(CH_LF);
	endtask

	// no LF: the line is cut at the length cap and judged there
	task automatic test_max_length_cut();
		for (int m = 0; m < 2; m++) begin
			set_strict(m[0]);
			send_byte(CH_DOLLAR);
			for (int i = 1; i < NSC_MAX_LINE; i++)
				send_byte("A");
		end
		send_text("$*00\n");        // next line starts clean
	endtask

	// strict_mode is only looked at when the body ends without '*'
	task automatic test_mode_change();
		set_strict(1'b1);
		send_text("$AB");
		set_strict(1'b0);
		send_text("\n");
		send_text("$AB");
		set_strict(1'b1);
		send_text("\n");
	endtask

	// one random line: mostly well-formed sentences, some noise and breakage
	task automatic random_line();
		octet_t line_q[$];
		octet_t c, sum, cks;
		int     n, pos;
		bit     lower;
		if ($urandom_range(99) < 10) begin
			n = $urandom_range(1, 20);
			repeat (n) line_q.push_back(octet_t'($urandom_range(255)));
			line_q.push_back(CH_LF);
		end else begin
			n = ($urandom_range(19) == 0) ? $urandom_range(60, 95) : $urandom_range(0, 14);
			line_q.push_back(CH_DOLLAR);
			sum = '0;
			repeat (n) begin
				do c = octet_t'($urandom_range(CH_SPACE, CH_TILDE));
				while (c == CH_STAR);
				sum ^= c;
				line_q.push_back(c);
			end
			if ($urandom_range(99) >= 12) begin
				cks   = sum;
				lower = 1'($urandom_range(1));
				if ($urandom_range(99) < 10)
					cks ^= octet_t'(1 << $urandom_range(7));
				line_q.push_back(CH_STAR);
				line_q.push_back(hex_char(cks[7:4], lower));
				if ($urandom_range(99) >= 5)
					line_q.push_back(hex_char(cks[3:0], 1'($urandom_range(1))));
			end
			case ($urandom_range(9))
				0, 1, 2, 3, 4: begin
					line_q.push_back(CH_CR);
					line_q.push_back(CH_LF);
				end
				5, 6: line_q.push_back(CH_LF);
				7: begin
					repeat ($urandom_range(1, 3)) line_q.push_back(CH_NUL);
					line_q.push_back(CH_LF);
				end
				8: begin
					line_q.push_back(CH_NUL);
					line_q.push_back(octet_t'($urandom_range(1, 255)));
					line_q.push_back(CH_LF);
				end
				default: begin
					line_q.push_back(octet_t'($urandom_range(255)));
					line_q.push_back(CH_LF);
				end
			endcase
			// occasional corruption of one byte, the '$' included
			if ($urandom_range(99) < 10) begin
				pos = $urandom_range(line_q.size() - 1);
				line_q[pos] = octet_t'($urandom_range(255));
			end
		end
		foreach (line_q[i])
			send_byte(line_q[i]);
	endtask

	task automatic test_random_traffic(input int unsigned gap, input int unsigned stall,
		input logic mode, input int unsigned n_bytes);
		int unsigned stop_at;
		set_strict(mode);
		gap_pct   = gap;
		stall_pct = stall;
		stop_at   = bytes_sent + n_bytes;
		while (bytes_sent < stop_at)
			random_line();
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		strict_q = 1'b1;
		clear_line();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		gap_pct   = 20;
		stall_pct = 49;
		test_sentence_basics();
		test_checksum_faults();
		test_nul_handling();
		test_max_length_cut();
		test_mode_change();

		test_random_traffic(20, 49, 1'b1, 55);
		test_random_traffic(20, 49, 1'b0, 55);
		test_random_traffic(49, 20, 1'b1, 55);
		test_random_traffic(49, 20, 1'b0, 55);
		test_random_traffic(0, 0, 1'b1, 55);
		test_random_traffic(0, 0, 1'b0, 55);

		drain();
		repeat (10) @(negedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
